// File: hdl/fplr_pkg.sv
// four point line rasterizer package: item structs, line mode codes, widths
// used by four_point_line_rasterizer; depends on nothing
`timescale 1ns / 1ps

package fplr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 8;
    localparam int ERR_BITS   = 14;
    localparam int STEP_BITS  = 12;
    localparam int LANES      = 4;
    localparam int CNT_BITS   = 3;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // line modes
    localparam logic [1:0] MODE_VERT    = 2'd0;
    localparam logic [1:0] MODE_HORIZ   = 2'd1;
    localparam logic [1:0] MODE_STEEP   = 2'd2;
    localparam logic [1:0] MODE_SHALLOW = 2'd3;

    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [COLOR_BITS-1:0] color;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_of_step;
        logic                  line_done;
    } t_out_item;

endpackage

// File: hdl/four_point_line_rasterizer.sv
// four point line rasterizer: start and step items in, pixel write items out
// depends on fplr_pkg
`timescale 1ns / 1ps

// Usage
//   input channel (i_in_valid, o_in_stall, i_in_data): kind 0 starts a line
//   with the given endpoints and color, kind 1 advances the current line one
//   step. A start item aborts any line in progress and emits nothing; a step
//   with no line in progress emits nothing.
//   output channel (o_out_valid, i_out_stall, o_out_data): one pixel write
//   per item, up to four per step, last_of_step on the final write of a step
//   and line_done on every write of the step that ends the line.
//   timing: the first write of a step is offered in the cycle after the
//   step is accepted. A step is computed combinationally into a four entry
//   result buffer, which drains one write per cycle while not stalled.
//   throughput: the next item is taken in the cycle its predecessor's last
//   write leaves, so with no stalls the block runs at one write per cycle,
//   apart from start items and empty steps, which emit no writes.
//   stall: the buffered writes hold while the receiver stalls; o_in_stall is
//   high while more than one write waits or the last one waits under a stall.
//   reset: synchronous, active low; clears the buffer and ends any line.
module four_point_line_rasterizer
    import fplr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // line state
    logic                  r_busy,  n_busy;
    logic [1:0]            r_mode,  n_mode;
    logic [COORD_BITS-1:0] r_cx [LANES];
    logic [COORD_BITS-1:0] n_cx [LANES];
    logic [COORD_BITS-1:0] r_cy [LANES];
    logic [COORD_BITS-1:0] n_cy [LANES];
    logic signed [ERR_BITS-1:0] r_err, n_err;
    logic [STEP_BITS-1:0]  r_steps, n_steps;
    logic [COORD_BITS-1:0] r_dx,    n_dx;
    logic [COORD_BITS-1:0] r_dy,    n_dy;
    logic                  r_down,  n_down;
    logic [COLOR_BITS-1:0] r_color, n_color;

    // result buffer, entry 0 is the one offered
    t_out_item             r_res [LANES];
    t_out_item             n_res [LANES];
    logic [CNT_BITS-1:0]   r_cnt,   n_cnt;

    logic                  in_fire;
    logic                  out_take;
    t_out_item             gen_res [LANES];
    logic [CNT_BITS-1:0]   gen_cnt;
    logic                  gen_done;

    // start decode
    logic                  swap;
    logic [COORD_BITS-1:0] xa, ya, xb, yb;
    logic [COORD_BITS-1:0] ylo, yhi;
    logic [COORD_BITS-1:0] sdx, sdy;
    logic                  sdown;
    logic [COORD_BITS:0]   vdiff;
    logic signed [ERR_BITS-1:0] ext_dx, ext_dy;

    function automatic logic [COORD_BITS-1:0] row_step(
        input logic [COORD_BITS-1:0] y,
        input logic                  inc
    );
        return inc ? y + 1'b1 : y - 1'b1;
    endfunction

    // handshakes
    assign out_take    = (r_cnt != '0) && !i_out_stall;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_res[0];
    assign o_in_stall  = (r_cnt > CNT_BITS'(1)) || ((r_cnt == CNT_BITS'(1)) && i_out_stall);
    assign in_fire     = i_in_valid && !o_in_stall;

    // endpoint ordering for start items
    assign swap  = i_in_data.x_start > i_in_data.x_end;
    assign xa    = swap ? i_in_data.x_end   : i_in_data.x_start;
    assign ya    = swap ? i_in_data.y_end   : i_in_data.y_start;
    assign xb    = swap ? i_in_data.x_start : i_in_data.x_end;
    assign yb    = swap ? i_in_data.y_start : i_in_data.y_end;
    assign ylo   = (ya > yb) ? yb : ya;
    assign yhi   = (ya > yb) ? ya : yb;
    assign sdown = ya < yb;
    assign sdx   = xb - xa;
    assign sdy   = sdown ? (yb - ya) : (ya - yb);

    assign vdiff  = {1'b0, r_cy[1]} - {1'b0, r_cy[0]};
    assign ext_dx = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_dx});
    assign ext_dy = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, r_dy});

    // one pass: state update and the writes of this item
    always_comb begin
        n_busy  = r_busy;
        n_mode  = r_mode;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_err   = r_err;
        n_steps = r_steps;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_down  = r_down;
        n_color = r_color;
        gen_cnt  = '0;
        gen_done = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            gen_res[i] = '0;
            gen_res[i].pixel_color = r_color;
        end

        if (in_fire && (i_in_data.kind == KIND_START)) begin
            n_busy  = 1'b1;
            n_color = i_in_data.color;
            n_err   = '0;
            n_steps = '0;
            n_down  = 1'b0;
            if (i_in_data.x_start == i_in_data.x_end) begin
                n_mode  = MODE_VERT;
                n_dx    = '0;
                n_dy    = yhi - ylo;
                n_cx[0] = xa;
                n_cy[0] = ylo;
                n_cx[1] = xa;
                n_cy[1] = yhi;
            end else if (ya == yb) begin
                n_mode  = MODE_HORIZ;
                n_dx    = sdx;
                n_dy    = '0;
                n_cx[0] = xa;
                n_cy[0] = ya;
                n_steps = STEP_BITS'(sdx);
            end else begin
                n_down  = sdown;
                n_dx    = sdx;
                n_dy    = sdy;
                n_cx[0] = xa;
                n_cy[0] = ya;
                n_cx[1] = xb;
                n_cy[1] = yb;
                for (int i = 2; i < LANES; i++) begin
                    n_cx[i] = xa + (sdx >> 1);
                    n_cy[i] = sdown ? ya + (sdy >> 1) : ya - (sdy >> 1);
                end
                if (sdx <= sdy) begin
                    n_mode  = MODE_STEEP;
                    n_err   = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, sdx})
                            - $signed({{(ERR_BITS-COORD_BITS+1){1'b0}}, sdy[COORD_BITS-1:1]});
                    n_steps = STEP_BITS'(sdy >> 2);
                end else begin
                    n_mode  = MODE_SHALLOW;
                    n_err   = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, sdy})
                            - $signed({{(ERR_BITS-COORD_BITS+1){1'b0}}, sdx[COORD_BITS-1:1]});
                    n_steps = STEP_BITS'(sdx >> 2);
                end
            end
        end else if (in_fire && r_busy) begin
            unique case (r_mode)
                MODE_VERT: begin
                    gen_cnt            = CNT_BITS'(2);
                    gen_res[0].pixel_x = r_cx[0];
                    gen_res[0].pixel_y = r_cy[0];
                    gen_res[1].pixel_x = r_cx[0];
                    gen_res[1].pixel_y = r_cy[1];
                    if (vdiff < (COORD_BITS+1)'(2)) begin
                        gen_done = 1'b1;
                    end else begin
                        n_cy[0] = r_cy[0] + 1'b1;
                        n_cy[1] = r_cy[1] - 1'b1;
                    end
                end
                MODE_HORIZ: begin
                    gen_cnt = (r_steps < STEP_BITS'(4)) ? r_steps[CNT_BITS-1:0]
                                                        : CNT_BITS'(4);
                    for (int i = 0; i < LANES; i++) begin
                        gen_res[i].pixel_x = r_cx[0] + COORD_BITS'(i);
                        gen_res[i].pixel_y = r_cy[0];
                    end
                    n_cx[0] = r_cx[0] + COORD_BITS'(gen_cnt);
                    n_steps = r_steps - STEP_BITS'(gen_cnt);
                    gen_done = (n_steps == '0);
                end
                default: begin
                    // steep and shallow diagonals share the four cursors
                    gen_cnt = CNT_BITS'(4);
                    for (int i = 0; i < LANES; i++) begin
                        gen_res[i].pixel_x = r_cx[i];
                        gen_res[i].pixel_y = r_cy[i];
                    end
                    if (r_steps == '0) begin
                        gen_done = 1'b1;
                    end else begin
                        n_steps = r_steps - 1'b1;
                        if (r_mode == MODE_STEEP) begin
                            if (!r_err[ERR_BITS-1]) begin
                                n_cx[0] = r_cx[0] + 1'b1;
                                n_cx[2] = r_cx[2] + 1'b1;
                                n_cx[1] = r_cx[1] - 1'b1;
                                n_cx[3] = r_cx[3] - 1'b1;
                                n_err   = r_err - ext_dy + ext_dx;
                            end else begin
                                n_err   = r_err + ext_dx;
                            end
                            n_cy[0] = row_step(r_cy[0], r_down);
                            n_cy[2] = row_step(r_cy[2], r_down);
                            n_cy[1] = row_step(r_cy[1], !r_down);
                            n_cy[3] = row_step(r_cy[3], !r_down);
                        end else begin
                            if (!r_err[ERR_BITS-1]) begin
                                n_cy[0] = row_step(r_cy[0], r_down);
                                n_cy[2] = row_step(r_cy[2], r_down);
                                n_cy[1] = row_step(r_cy[1], !r_down);
                                n_cy[3] = row_step(r_cy[3], !r_down);
                                n_err   = r_err - ext_dx + ext_dy;
                            end else begin
                                n_err   = r_err + ext_dy;
                            end
                            n_cx[0] = r_cx[0] + 1'b1;
                            n_cx[2] = r_cx[2] + 1'b1;
                            n_cx[1] = r_cx[1] - 1'b1;
                            n_cx[3] = r_cx[3] - 1'b1;
                        end
                    end
                end
            endcase
            if (gen_done) begin
                n_busy = 1'b0;
            end
        end

        // mark flags on the writes of this step
        for (int i = 0; i < LANES; i++) begin
            gen_res[i].line_done    = gen_done;
            gen_res[i].last_of_step = (CNT_BITS'(i + 1) == gen_cnt);
        end
    end

    // result buffer: load a fresh step or shift out the taken item
    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (in_fire && (gen_cnt != '0)) begin
            n_res = gen_res;
            n_cnt = gen_cnt;
        end else if (out_take) begin
            for (int i = 0; i < LANES - 1; i++) begin
                n_res[i] = r_res[i + 1];
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    // control and line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_mode  <= MODE_VERT;
            r_cnt   <= '0;
            r_err   <= '0;
            r_steps <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_down  <= 1'b0;
            r_color <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_cx[i] <= '0;
                r_cy[i] <= '0;
            end
        end else begin
            r_busy  <= n_busy;
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_steps <= n_steps;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_down  <= n_down;
            r_color <= n_color;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// File: dv/tb_four_point_line_rasterizer.sv
// testbench for four_point_line_rasterizer: directed and random start and step items,
// a line predictor built from the mode rules, and in-order checking of pixel write items
// depends on fplr_pkg and the rasterizer rtl
`timescale 1ns / 1ps

module tb_four_point_line_rasterizer;
    import fplr_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int TAIL_CYCLES     = 8;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    // handshake and idling control
    logic      in_fire;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        mismatches = 0;
    int        cycles = 0;

    t_in_item  pending_q [$];
    t_out_item pixel_q [$];

    // predicted line state
    logic                  line_active;
    logic [1:0]            line_kind;
    logic [COORD_BITS-1:0] cur_x [LANES];
    logic [COORD_BITS-1:0] cur_y [LANES];
    int                    err_acc;
    int                    moves_left;
    logic [COORD_BITS-1:0] span_x;
    logic [COORD_BITS-1:0] span_y;
    logic                  rows_down;
    logic [COLOR_BITS-1:0] ink;

    always #5 i_clk = ~i_clk;

    four_point_line_rasterizer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic t_out_item pix(input logic [COORD_BITS-1:0] x,
                                      input logic [COORD_BITS-1:0] y);
        t_out_item p;
        p.pixel_x      = x;
        p.pixel_y      = y;
        p.pixel_color  = ink;
        p.last_of_step = 1'b0;
        p.line_done    = 1'b0;
        return p;
    endfunction

    // a row move toward the far end follows the line slope, back toward the near end opposes it
    function automatic logic [COORD_BITS-1:0] row_step(input logic [COORD_BITS-1:0] y,
                                                       input logic toward_far);
        logic inc;
        inc = toward_far ? rows_down : !rows_down;
        return inc ? y + 1'b1 : y - 1'b1;
    endfunction

    // cursors 0 and 2 head right, 1 and 3 head left
    task automatic move_cols();
        cur_x[0] = cur_x[0] + 1'b1;
        cur_x[2] = cur_x[2] + 1'b1;
        cur_x[1] = cur_x[1] - 1'b1;
        cur_x[3] = cur_x[3] - 1'b1;
    endtask

    task automatic move_rows();
        cur_y[0] = row_step(cur_y[0], 1'b1);
        cur_y[2] = row_step(cur_y[2], 1'b1);
        cur_y[1] = row_step(cur_y[1], 1'b0);
        cur_y[3] = row_step(cur_y[3], 1'b0);
    endtask

    // predict the pixel writes of one accepted item and queue them
    task automatic rasterize_item(input t_in_item it);
        t_out_item             wr [LANES];
        logic [COORD_BITS-1:0] xa, ya, xb, yb, t;
        logic [31:0]           gap;
        logic                  done;
        int                    n, cnt, i;
        n    = 0;
        done = 1'b0;
        if (it.kind == KIND_START) begin
            // latch a new line, dropping whatever was in progress
            ink         = it.color;
            xa          = it.x_start;
            ya          = it.y_start;
            xb          = it.x_end;
            yb          = it.y_end;
            line_active = 1'b1;
            err_acc     = 0;
            moves_left  = 0;
            rows_down   = 1'b0;
            if (xa == xb) begin
                if (ya > yb) begin
                    t  = ya;
                    ya = yb;
                    yb = t;
                end
                line_kind = MODE_VERT;
                span_x    = '0;
                span_y    = yb - ya;
                cur_x[0]  = xa;
                cur_y[0]  = ya;
                cur_x[1]  = xa;
                cur_y[1]  = yb;
            end else begin
                if (xa > xb) begin
                    t  = xa;
                    xa = xb;
                    xb = t;
                    t  = ya;
                    ya = yb;
                    yb = t;
                end
                span_x   = xb - xa;
                cur_x[0] = xa;
                cur_y[0] = ya;
                if (ya == yb) begin
                    line_kind  = MODE_HORIZ;
                    span_y     = '0;
                    moves_left = int'(span_x);
                end else begin
                    rows_down = ya < yb;
                    span_y    = rows_down ? yb - ya : ya - yb;
                    cur_x[1]  = xb;
                    cur_y[1]  = yb;
                    // midpoint cursors
                    for (i = 2; i < LANES; i++) begin
                        cur_x[i] = xa + span_x / 2;
                        cur_y[i] = rows_down ? ya + span_y / 2 : ya - span_y / 2;
                    end
                    if (span_x <= span_y) begin
                        line_kind  = MODE_STEEP;
                        err_acc    = int'(span_x) - int'(span_y / 2);
                        moves_left = int'(span_y / 4);
                    end else begin
                        line_kind  = MODE_SHALLOW;
                        err_acc    = int'(span_y) - int'(span_x / 2);
                        moves_left = int'(span_x / 4);
                    end
                end
            end
        end else if (line_active) begin
            case (line_kind)
                // two cursors walk inward, both ends inclusive
                MODE_VERT: begin
                    wr[0] = pix(cur_x[0], cur_y[0]);
                    wr[1] = pix(cur_x[0], cur_y[1]);
                    n     = 2;
                    gap   = 32'(cur_y[1]) - 32'(cur_y[0]);
                    if (gap < 2) begin
                        done = 1'b1;
                    end else begin
                        cur_y[0] = cur_y[0] + 1'b1;
                        cur_y[1] = cur_y[1] - 1'b1;
                    end
                end
                // up to four pixels per step, right end left out
                MODE_HORIZ: begin
                    cnt = moves_left < LANES ? moves_left : LANES;
                    for (i = 0; i < cnt; i++) begin
                        wr[i] = pix(cur_x[0] + COORD_BITS'(i), cur_y[0]);
                    end
                    n          = cnt;
                    cur_x[0]   = cur_x[0] + COORD_BITS'(cnt);
                    moves_left = moves_left - cnt;
                    done       = moves_left == 0;
                end
                // four cursors sharing one midpoint error term
                default: begin
                    for (i = 0; i < LANES; i++) begin
                        wr[i] = pix(cur_x[i], cur_y[i]);
                    end
                    n = LANES;
                    if (moves_left == 0) begin
                        done = 1'b1;
                    end else if (line_kind == MODE_STEEP) begin
                        if (err_acc >= 0) begin
                            move_cols();
                            err_acc = err_acc - int'(span_y);
                        end
                        move_rows();
                        err_acc    = err_acc + int'(span_x);
                        moves_left = moves_left - 1;
                    end else begin
                        if (err_acc >= 0) begin
                            move_rows();
                            err_acc = err_acc - int'(span_x);
                        end
                        move_cols();
                        err_acc    = err_acc + int'(span_y);
                        moves_left = moves_left - 1;
                    end
                end
            endcase
            if (n > 0) begin
                wr[n-1].last_of_step = 1'b1;
            end
            for (i = 0; i < n; i++) begin
                wr[i].line_done = done;
                pixel_q.push_back(wr[i]);
            end
            if (done) begin
                line_active = 1'b0;
            end
        end
    endtask

    // a start item and its step items, step payload bits left random
    task automatic push_line(input logic [COORD_BITS-1:0] xa, input logic [COORD_BITS-1:0] ya,
                             input logic [COORD_BITS-1:0] xb, input logic [COORD_BITS-1:0] yb,
                             input logic [COLOR_BITS-1:0] c, input int steps);
        t_in_item it;
        int       k;
        it.kind    = KIND_START;
        it.x_start = xa;
        it.y_start = ya;
        it.x_end   = xb;
        it.y_end   = yb;
        it.color   = c;
        pending_q.push_back(it);
        for (k = 0; k < steps; k++) begin
            it.kind    = KIND_STEP;
            it.x_start = COORD_BITS'($urandom);
            it.y_start = COORD_BITS'($urandom);
            it.x_end   = COORD_BITS'($urandom);
            it.y_end   = COORD_BITS'($urandom);
            it.color   = COLOR_BITS'($urandom);
            pending_q.push_back(it);
        end
    endtask

    // second endpoint a given distance away, turned back where it would leave the range
    function automatic logic [COORD_BITS-1:0] shift_coord(input logic [COORD_BITS-1:0] base,
                                                          input int span);
        if (int'(base) + span > int'(COORD_MAX)) begin
            return base - COORD_BITS'(span);
        end
        return base + COORD_BITS'(span);
    endfunction

    function automatic string describe(input t_out_item p);
        return $sformatf("x=%0d y=%0d color=%0d last=%b done=%b",
                         p.pixel_x, p.pixel_y, p.pixel_color, p.last_of_step, p.line_done);
    endfunction

    // driver: next pending item once the current one is taken, random sender gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_fire) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data  <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= $urandom_range(0, 99) < recv_stall_pct;
        end
    end

    // monitor: check pixel writes in order, predict from accepted items
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("pixel write with none expected: got %s", describe(out_data));
                    end
                end else begin
                    want = pixel_q.pop_front();
                    if (out_data !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("pixel write mismatch: expected %s, got %s",
                                     describe(want), describe(out_data));
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                rasterize_item(in_data);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        t_in_item              lone_step;
        logic [COORD_BITS-1:0] xa, ya, xb, yb;
        int                    ph, queued, shape, reach, dx, dy, need, mix;

        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        send_idle_pct  = 18;
        recv_stall_pct = 73;
        line_active    = 1'b0;
        line_kind      = MODE_VERT;
        for (int i = 0; i < LANES; i++) begin
            cur_x[i] = '0;
            cur_y[i] = '0;
        end
        err_acc    = 0;
        moves_left = 0;
        span_x     = '0;
        span_y     = '0;
        rows_down  = 1'b0;
        ink        = '0;

        // directed lines
        lone_step      = '1;
        lone_step.kind = KIND_STEP;
        pending_q.push_back(lone_step);                               // step with no line
        push_line('0, '0, '0, '0, 8'h00, 2);                          // point, then idle step
        push_line(COORD_MAX, COORD_MAX, COORD_MAX, '0, 8'hFF, 1);     // full height, aborted
        push_line(COORD_MAX, COORD_MAX, '0, COORD_MAX, 8'hA5, 2);     // full width, aborted
        push_line(12'd5, 12'd7, 12'd6, 12'd7, 8'h5A, 1);              // single pixel row
        push_line(12'd20, 12'd3, 12'd15, 12'd3, 8'h3C, 2);            // partial last step
        push_line(12'd10, 12'd40, 12'd13, 12'd30, 8'hC3, 3);          // steep, rows upward
        push_line('0, '0, 12'd9, 12'd2, 8'h0F, 3);                    // shallow, rows downward
        push_line(COORD_MAX, COORD_MAX, '0, '0, 8'hF0, 2);            // exact diagonal, aborted

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 73 : 0;
            recv_stall_pct = (ph == 0) ? 73 : (ph == 1) ? 18 : 0;
            queued = 0;
            // random lines: mostly complete, some cut short, some followed by idle steps
            while (queued < ITEMS_PER_PHASE) begin
                shape = $urandom_range(0, 9);
                reach = ($urandom_range(0, 9) == 0) ? 160 : 24;
                xa    = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
                ya    = COORD_BITS'($urandom_range(0, int'(COORD_MAX)));
                xb    = (shape <= 2) ? xa : shift_coord(xa, $urandom_range(1, reach));
                yb    = (shape == 0 || shape == 3 || shape == 4) ? ya
                        : shift_coord(ya, $urandom_range(1, reach));
                dx    = (xa > xb) ? int'(xa - xb) : int'(xb - xa);
                dy    = (ya > yb) ? int'(ya - yb) : int'(yb - ya);
                if (dx == 0) begin
                    need = dy / 2 + 1;
                end else if (dy == 0) begin
                    need = (dx + 3) / 4;
                end else begin
                    need = ((dx <= dy) ? dy : dx) / 4 + 1;
                end
                mix = $urandom_range(0, 9);
                if (mix == 0) begin
                    need = $urandom_range(0, need - 1);
                end else if (mix <= 2) begin
                    need = need + $urandom_range(1, 2);
                end
                push_line(xa, ya, xb, yb, COLOR_BITS'($urandom_range(0, 255)), need);
                queued = queued + need + 1;
            end
            while (pending_q.size() != 0 || in_valid || pixel_q.size() != 0) begin
                @(posedge i_clk);
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
